### hdl/hcbd_pkg.sv
// Shared types and constants for the chunked body decoder.
// Used by the front, queue, back and top-level modules and by the port checker.
`default_nettype none
package hcbd_pkg;

   typedef enum logic [2:0] {
      KIND_PAYLOAD     = 3'd0,
      KIND_FINISHED    = 3'd1,
      KIND_NOT_CHUNKED = 3'd2,
      KIND_TRUNCATED   = 3'd3,
      KIND_BAD_DELIM   = 3'd4
   } kind_type;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   // Everything one body byte produces: a first result and an optional second one.
   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       extra;
      kind_type   extra_kind;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

endpackage
`default_nettype wire

### hdl/hcbd_front.sv
// Front parser: accepts body bytes and runs the chunk framing state machine.
// Depends on hcbd_pkg; pushes one entry per result-producing byte into hcbd_queue.
`default_nettype none
module hcbd_front #(
   parameter int SIZE_BITS = 32
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  accept,
   input  wire  [7:0]           in_byte,
   input  wire                  first,
   input  wire                  last,
   output hcbd_pkg::push_type   push_out
);

   typedef enum logic [2:0] {
      PH_LEAD    = 3'd0,
      PH_DIGITS  = 3'd1,
      PH_REST    = 3'd2,
      PH_DATA    = 3'd3,
      PH_DATA_CR = 3'd4,
      PH_DATA_LF = 3'd5,
      PH_DONE    = 3'd6
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [SIZE_BITS-1:0] remaining_ff, remaining_in;
   logic                 saw_digit_ff, saw_digit_in;
   logic                 pending_cr_ff, pending_cr_in;
   logic                 overflow_ff, overflow_in;

   phase_type            ph;
   logic [SIZE_BITS-1:0] rem;
   logic [SIZE_BITS-1:0] rem_dec;
   logic                 sd, pcr, ovf;
   logic                 is_hex;
   logic [3:0]           hex_val;

   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h61 + 8'd10)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h41 + 8'd10)};
      return r;
   endfunction

   assign {is_hex, hex_val} = hex_decode(in_byte);

   always_comb begin
      // A first byte restarts the parse before it is handled.
      ph  = first ? PH_LEAD : phase_ff;
      rem = first ? '0 : remaining_ff;
      sd  = first ? 1'b0 : saw_digit_ff;
      pcr = first ? 1'b0 : pending_cr_ff;
      ovf = first ? 1'b0 : overflow_ff;
      rem_dec = rem - 1'b1;

      phase_in      = ph;
      remaining_in  = rem;
      saw_digit_in  = sd;
      pending_cr_in = pcr;
      overflow_in   = ovf;

      push_out                  = '0;
      push_out.entry.kind       = hcbd_pkg::KIND_NOT_CHUNKED;
      push_out.entry.extra_kind = hcbd_pkg::KIND_NOT_CHUNKED;

      unique case (ph)
         PH_LEAD, PH_DIGITS, PH_REST: begin
            if (pcr && in_byte == hcbd_pkg::CHAR_LF) begin
               pending_cr_in = 1'b0;
               if (!sd || ovf) begin
                  push_out.push = 1'b1;
                  phase_in = PH_DONE;
               end else if (rem == '0) begin
                  push_out.push = 1'b1;
                  push_out.entry.kind = hcbd_pkg::KIND_FINISHED;
                  phase_in = PH_DONE;
               end else if (last) begin
                  push_out.push = 1'b1;
                  push_out.entry.kind = hcbd_pkg::KIND_TRUNCATED;
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_DATA;
               end
            end else begin
               pending_cr_in = (in_byte == hcbd_pkg::CHAR_CR);
               if (ph == PH_LEAD && (in_byte == hcbd_pkg::CHAR_SPACE ||
                                     in_byte == hcbd_pkg::CHAR_TAB)) begin
                  phase_in = PH_LEAD;
               end else if ((ph == PH_LEAD || ph == PH_DIGITS) && is_hex) begin
                  saw_digit_in = 1'b1;
                  phase_in = PH_DIGITS;
                  // A digit that would push bits out of the size marks overflow instead.
                  if (rem[SIZE_BITS-1 -: 4] != 4'd0) overflow_in = 1'b1;
                  else remaining_in = {rem[SIZE_BITS-5:0], hex_val};
               end else begin
                  phase_in = PH_REST;
               end
               if (last) begin
                  push_out.push = 1'b1;
                  phase_in = PH_DONE;
               end
            end
         end
         PH_DATA: begin
            push_out.push = 1'b1;
            push_out.entry.data = in_byte;
            push_out.entry.kind = hcbd_pkg::KIND_PAYLOAD;
            remaining_in = rem_dec;
            if (rem_dec == '0) phase_in = PH_DATA_CR;
            if (last) begin
               push_out.entry.extra = 1'b1;
               push_out.entry.extra_kind = (rem_dec == '0) ? hcbd_pkg::KIND_BAD_DELIM
                                                           : hcbd_pkg::KIND_TRUNCATED;
               phase_in = PH_DONE;
            end
         end
         PH_DATA_CR: begin
            if (in_byte != hcbd_pkg::CHAR_CR || last) begin
               push_out.push = 1'b1;
               push_out.entry.kind = hcbd_pkg::KIND_BAD_DELIM;
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_DATA_LF;
            end
         end
         PH_DATA_LF: begin
            if (in_byte != hcbd_pkg::CHAR_LF) begin
               push_out.push = 1'b1;
               push_out.entry.kind = hcbd_pkg::KIND_BAD_DELIM;
               phase_in = PH_DONE;
            end else begin
               phase_in      = PH_LEAD;
               remaining_in  = '0;
               saw_digit_in  = 1'b0;
               pending_cr_in = 1'b0;
               overflow_in   = 1'b0;
               if (last) begin
                  push_out.push = 1'b1;
                  phase_in = PH_DONE;
               end
            end
         end
         default: begin
            phase_in = ph;
         end
      endcase

      if (!accept) push_out.push = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEAD;
         remaining_ff  <= '0;
         saw_digit_ff  <= 1'b0;
         pending_cr_ff <= 1'b0;
         overflow_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         remaining_ff  <= remaining_in;
         saw_digit_ff  <= saw_digit_in;
         pending_cr_ff <= pending_cr_in;
         overflow_ff   <= overflow_in;
      end
   end

endmodule
`default_nettype wire

### hdl/hcbd_queue.sv
// Small result queue between the parser front and the output back.
// Depends on hcbd_pkg for the entry type and depth.
`default_nettype none
module hcbd_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  hcbd_pkg::push_type   push_in,
   input  wire                  pop,
   output logic                 full,
   output logic                 empty,
   output hcbd_pkg::entry_type  head
);

   hcbd_pkg::entry_type entries_ff [hcbd_pkg::QUEUE_DEPTH];
   logic [hcbd_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [hcbd_pkg::QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign full  = (count_ff == (hcbd_pkg::QUEUE_PTR_BITS+1)'(hcbd_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_in.push && !(pop && !empty)) count_in = count_ff + 1'b1;
      else if (!push_in.push && pop && !empty) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push_in.push) entries_ff[wr_ptr_ff] <= push_in.entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_in.push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop && !empty) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

### hdl/hcbd_back.sv
// Output back end: turns queued entries into one result transaction per cycle while rsp_tready is high.
// Depends on hcbd_pkg; reads the head of hcbd_queue and pops it when done.
`default_nettype none
module hcbd_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  empty,
   input  hcbd_pkg::entry_type  head,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic [2:0]           rsp_tuser,
   output logic                 rsp_tlast
);

   // High while the second result of the head entry is being offered.
   logic second_ff;
   logic fire;

   assign rsp_tvalid = !empty;
   assign fire       = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = second_ff ? 8'd0 : head.data;
   assign rsp_tuser  = second_ff ? head.extra_kind : head.kind;
   assign rsp_tlast  = second_ff || !head.extra;
   assign pop        = fire && rsp_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else if (fire) begin
         second_ff <= !rsp_tlast;
      end
   end

endmodule
`default_nettype wire

### hdl/http_chunked_body_decoder.sv
// HTTP/1.1 chunked body decoder. Takes one body byte per cycle on req_ when ready, gives
// payload bytes and status results on rsp_. Built from hcbd_front, hcbd_queue, hcbd_back.
//
// Each accepted byte is parsed in the cycle it arrives, so the input side takes one byte
// per clock while the queue is not full. Data bytes give one payload result each; a byte
// that ends a chunk size line or the body, or breaks the CRLF after chunk data, may give
// a status result (finished, not_chunked, truncated, bad delimiter) and, when the body
// ends inside chunk data, the payload byte and then a status. A four-entry queue between
// the parser and the output stage absorbs that and lets req_tready stay high while rsp_
// stalls until the queue fills, which registers results before rsp_ offers them. After
// a finished or error result, bytes give no results until a byte marked with req_tuser.
`default_nettype none
module http_chunked_body_decoder #(
   parameter int SIZE_BITS = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] in_byte
   input  wire         req_tuser,   // [0] first
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [2:0]  rsp_tuser,   // [2:0] out_kind
   output logic        rsp_tlast
);

   hcbd_pkg::push_type  push;
   hcbd_pkg::entry_type head;
   logic full, empty, pop, accept;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   hcbd_front #(.SIZE_BITS(SIZE_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_byte  (req_tdata),
      .first    (req_tuser),
      .last     (req_tlast),
      .push_out (push)
   );

   hcbd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .full    (full),
      .empty   (empty),
      .head    (head)
   );

   hcbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

### hdl/hcbd_checker.sv
// Port checker for the chunked body decoder, bound to the top level.
// Depends on hcbd_pkg for the result kind codes.
`default_nettype none
module hcbd_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [7:0]  rsp_tdata,
   input wire [2:0]  rsp_tuser,
   input wire        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != hcbd_pkg::KIND_PAYLOAD |-> rsp_tlast)
      else $error("status result not marked last");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != hcbd_pkg::KIND_PAYLOAD |-> rsp_tdata == 8'd0)
      else $error("status result carries data");

   a_split_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tuser == hcbd_pkg::KIND_TRUNCATED ||
                        rsp_tuser == hcbd_pkg::KIND_BAD_DELIM))
      else $error("payload not followed by its closing status");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
